// File: rtl/core/spa_pkg.sv
// Shared types and constants for the sparse polynomial adder.
// No dependencies; every other file in rtl/core uses this package.
package spa_pkg;

  localparam int COEF_W             = 32;
  localparam int EXPON_W            = 16;
  localparam int REQ_W              = 2;
  localparam int TERMS_PER_POLY_DEF = 16;
  localparam int QUEUE_DEPTH        = 4;

  localparam logic [REQ_W-1:0] REQ_LOAD_A = 2'd0;
  localparam logic [REQ_W-1:0] REQ_LOAD_B = 2'd1;
  localparam logic [REQ_W-1:0] REQ_RUN    = 2'd2;

  localparam logic signed [COEF_W-1:0] COEF_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [COEF_W-1:0] COEF_MIN = 32'sh8000_0000;

  typedef enum logic [1:0] {
    OP_LOAD_A,
    OP_LOAD_B,
    OP_RUN
  } op_t;

  typedef struct packed {
    op_t                        op;
    logic signed [COEF_W-1:0]   coef;
    logic        [EXPON_W-1:0]  expon;
  } cmd_t;

  typedef struct packed {
    logic signed [COEF_W-1:0]   coef;
    logic        [EXPON_W-1:0]  expon;
  } term_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_FETCH,
    B_MERGE,
    B_FLUSH
  } bstate_t;

  typedef struct packed {
    logic in_run;
    logic pend_valid;
  } bstat_t;

endpackage

// File: rtl/core/spa_front.sv
// Front end: takes requests, decodes the request type and queues commands.
// Depends on spa_pkg.
module spa_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          req_valid,
  output logic                          req_stall,
  input  logic [spa_pkg::REQ_W-1:0]     req_type,
  input  logic signed [spa_pkg::COEF_W-1:0] coef,
  input  logic [spa_pkg::EXPON_W-1:0]   expon,
  output logic                          q_valid,
  output spa_pkg::cmd_t                 q_cmd,
  input  logic                          q_pop
);
  import spa_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int NW = $clog2(QUEUE_DEPTH + 1);

  cmd_t          fifo [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [NW-1:0] fill;
  logic          known;
  logic          push;
  logic          pop;
  cmd_t          cmd;

  always_comb begin
    cmd.coef  = coef;
    cmd.expon = expon;
    case (req_type)
      REQ_LOAD_A: cmd.op = OP_LOAD_A;
      REQ_LOAD_B: cmd.op = OP_LOAD_B;
      default:    cmd.op = OP_RUN;
    endcase
  end

  // drop unknown request types here so the back end never sees them
  assign known     = req_type inside {REQ_LOAD_A, REQ_LOAD_B, REQ_RUN};
  assign req_stall = (fill == NW'(QUEUE_DEPTH));
  assign push      = req_valid && !req_stall && known;
  assign q_valid   = (fill != '0);
  assign pop       = q_pop && q_valid;
  assign q_cmd     = fifo[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      fifo[wr_ptr] <= cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        fill <= fill + NW'(1);
      end else if (pop && !push) begin
        fill <= fill - NW'(1);
      end
    end
  end

endmodule

// File: rtl/core/spa_merge.sv
// Back end: term stores, load handling and the sorted merge with output register.
// Depends on spa_pkg.
module spa_merge #(
  parameter int TERMS_PER_POLY = spa_pkg::TERMS_PER_POLY_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              q_valid,
  input  spa_pkg::cmd_t                     q_cmd,
  output logic                              q_pop,
  output logic                              res_valid,
  input  logic                              res_stall,
  output logic signed [spa_pkg::COEF_W-1:0] sum_coef,
  output logic [spa_pkg::EXPON_W-1:0]       sum_expon,
  output logic                              term_valid,
  output logic                              last,
  output logic                              overflow,
  output spa_pkg::bstat_t                   stat
);
  import spa_pkg::*;

  localparam int CW = $clog2(TERMS_PER_POLY + 1);
  localparam int IW = (TERMS_PER_POLY > 1) ? $clog2(TERMS_PER_POLY) : 1;

  term_t   mem_a [TERMS_PER_POLY];
  term_t   mem_b [TERMS_PER_POLY];
  term_t   rd_a;
  term_t   rd_b;
  term_t   pend;
  term_t   cand;
  logic    pend_valid;
  logic    ovf;
  logic [CW-1:0] cnt_a;
  logic [CW-1:0] cnt_b;
  logic [CW-1:0] i;
  logic [CW-1:0] j;
  bstate_t state;
  bstate_t state_next;

  logic             a_has;
  logic             b_has;
  logic             both_done;
  logic             out_free;
  logic             cand_v;
  logic             inc_i;
  logic             inc_j;
  logic             step_ok;
  logic             run_start;
  logic             wr_a;
  logic             wr_b;
  logic             full_drop;
  logic             flush_go;
  logic             res_load;
  logic signed [COEF_W:0] wide_sum;
  logic signed [COEF_W-1:0] sat_sum;

  assign a_has     = (i < cnt_a);
  assign b_has     = (j < cnt_b);
  assign both_done = !a_has && !b_has;
  assign out_free  = !res_valid || !res_stall;

  assign wide_sum = {rd_a.coef[COEF_W-1], rd_a.coef} + {rd_b.coef[COEF_W-1], rd_b.coef};
  always_comb begin
    if (wide_sum[COEF_W] != wide_sum[COEF_W-1]) begin
      sat_sum = wide_sum[COEF_W] ? COEF_MIN : COEF_MAX;
    end else begin
      sat_sum = wide_sum[COEF_W-1:0];
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      B_IDLE: begin
        if (q_valid && q_cmd.op == OP_RUN) begin
          state_next = B_FETCH;
        end
      end
      B_FETCH: state_next = both_done ? B_FLUSH : B_MERGE;
      B_MERGE: begin
        if (step_ok) begin
          state_next = B_FETCH;
        end
      end
      B_FLUSH: begin
        if (out_free) begin
          state_next = B_IDLE;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    q_pop     = 1'b0;
    run_start = 1'b0;
    wr_a      = 1'b0;
    wr_b      = 1'b0;
    full_drop = 1'b0;
    cand_v    = 1'b0;
    cand      = rd_a;
    inc_i     = 1'b0;
    inc_j     = 1'b0;
    step_ok   = 1'b0;
    flush_go  = 1'b0;
    case (state)
      B_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          case (q_cmd.op)
            OP_LOAD_A: begin
              if (cnt_a >= CW'(TERMS_PER_POLY)) begin
                full_drop = 1'b1;
              end else begin
                wr_a = 1'b1;
              end
            end
            OP_LOAD_B: begin
              if (cnt_b >= CW'(TERMS_PER_POLY)) begin
                full_drop = 1'b1;
              end else begin
                wr_b = 1'b1;
              end
            end
            default: run_start = 1'b1;
          endcase
        end
      end
      B_MERGE: begin
        if (a_has && b_has) begin
          if (rd_a.expon == rd_b.expon) begin
            cand.coef = sat_sum;
            cand_v    = (sat_sum != '0);
            inc_i     = 1'b1;
            inc_j     = 1'b1;
          end else if (rd_a.expon > rd_b.expon) begin
            cand_v = 1'b1;
            inc_i  = 1'b1;
          end else begin
            cand   = rd_b;
            cand_v = 1'b1;
            inc_j  = 1'b1;
          end
        end else if (a_has) begin
          cand_v = 1'b1;
          inc_i  = 1'b1;
        end else begin
          cand   = rd_b;
          cand_v = 1'b1;
          inc_j  = 1'b1;
        end
        // hold the step while the pending term cannot move on
        step_ok = !cand_v || !pend_valid || out_free;
      end
      B_FLUSH: flush_go = out_free;
      default: ;
    endcase
  end

  assign res_load = (step_ok && cand_v && pend_valid) || flush_go;

  always_ff @(posedge clk) begin
    if (wr_a) begin
      mem_a[cnt_a[IW-1:0]] <= '{coef: q_cmd.coef, expon: q_cmd.expon};
    end
    if (wr_b) begin
      mem_b[cnt_b[IW-1:0]] <= '{coef: q_cmd.coef, expon: q_cmd.expon};
    end
    if (state == B_FETCH) begin
      rd_a <= mem_a[i[IW-1:0]];
      rd_b <= mem_b[j[IW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= B_IDLE;
      cnt_a      <= '0;
      cnt_b      <= '0;
      ovf        <= 1'b0;
      i          <= '0;
      j          <= '0;
      pend_valid <= 1'b0;
      res_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (res_valid && !res_stall) begin
        res_valid <= 1'b0;
      end
      if (wr_a) begin
        cnt_a <= cnt_a + CW'(1);
      end
      if (wr_b) begin
        cnt_b <= cnt_b + CW'(1);
      end
      if (full_drop) begin
        ovf <= 1'b1;
      end
      if (run_start) begin
        i <= '0;
        j <= '0;
      end
      if (step_ok) begin
        if (inc_i) begin
          i <= i + CW'(1);
        end
        if (inc_j) begin
          j <= j + CW'(1);
        end
        if (cand_v) begin
          pend_valid <= 1'b1;
        end
      end
      if (flush_go) begin
        pend_valid <= 1'b0;
        cnt_a      <= '0;
        cnt_b      <= '0;
        ovf        <= 1'b0;
      end
    end
  end

  // payload of the pending term and the output register
  always_ff @(posedge clk) begin
    if (step_ok && cand_v) begin
      pend <= cand;
      if (pend_valid) begin
        sum_coef   <= pend.coef;
        sum_expon  <= pend.expon;
        term_valid <= 1'b1;
        last       <= 1'b0;
        overflow   <= ovf;
      end
    end
    if (flush_go) begin
      sum_coef   <= pend_valid ? pend.coef : '0;
      sum_expon  <= pend_valid ? pend.expon : '0;
      term_valid <= pend_valid;
      last       <= 1'b1;
      overflow   <= ovf;
    end
  end

  assign stat = '{in_run: (state != B_IDLE), pend_valid: pend_valid};

endmodule

// File: rtl/core/sparse_polynomial_add.sv
// Top level of the sparse polynomial adder: request front end, command queue, merge back end.
// Depends on spa_pkg, spa_front and spa_merge.
//
//   channel  | handshake            | payload
//   request  | req_valid, req_stall | req_type, coef, expon
//   result   | res_valid, res_stall | sum_coef, sum_expon, term_valid, last, overflow
//
// An idle back end takes a load from the queue; requests queue four deep ahead of it.
// A run leaves the queue; each merge step is a store read (B_FETCH), then a compare and add
// (B_MERGE), one step per unpaired term and one per pair of equal exponents; a final store
// read and B_FLUSH end the run. The single store read port per list sets that pace.
// Reset clears counts, the overflow flag, the queue and res_valid; stores need none.
// A stalled result holds the back end only once the pending term also has to move.
module sparse_polynomial_add #(
  parameter int TERMS_PER_POLY = spa_pkg::TERMS_PER_POLY_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              req_valid,
  output logic                              req_stall,
  input  logic [spa_pkg::REQ_W-1:0]         req_type,
  input  logic signed [spa_pkg::COEF_W-1:0] coef,
  input  logic [spa_pkg::EXPON_W-1:0]       expon,
  output logic                              res_valid,
  input  logic                              res_stall,
  output logic signed [spa_pkg::COEF_W-1:0] sum_coef,
  output logic [spa_pkg::EXPON_W-1:0]       sum_expon,
  output logic                              term_valid,
  output logic                              last,
  output logic                              overflow
);
  import spa_pkg::*;

  logic   q_valid;
  cmd_t   q_cmd;
  logic   q_pop;
  bstat_t stat;

  spa_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_type  (req_type),
    .coef      (coef),
    .expon     (expon),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .q_pop     (q_pop)
  );

  spa_merge #(
    .TERMS_PER_POLY (TERMS_PER_POLY)
  ) u_merge (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_cmd      (q_cmd),
    .q_pop      (q_pop),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .sum_coef   (sum_coef),
    .sum_expon  (sum_expon),
    .term_valid (term_valid),
    .last       (last),
    .overflow   (overflow),
    .stat       (stat)
  );

  // an empty result closes its run and carries no term
  a_empty_result: assert property (@(posedge clk) disable iff (rst)
    res_valid && !term_valid |-> last && sum_coef == '0 && sum_expon == '0)
    else $error("empty result is not a closing zero term");

  // no term may wait in the back end between runs
  a_no_pend_idle: assert property (@(posedge clk) disable iff (rst)
    !stat.in_run |-> !stat.pend_valid)
    else $error("pending term left over after run");

  // a new result appears only while a run is active or just finished it
  a_result_in_run: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(stat.in_run))
    else $error("result produced outside a run");

endmodule

// File: verif/sparse_polynomial_add_tb.sv
// Self-checking testbench for sparse_polynomial_add: directed and random load/run requests,
// with a scoreboard that merges its own copy of both term lists.
// Depends on spa_pkg and the sparse_polynomial_add RTL.
`timescale 1ns / 1ps

module sparse_polynomial_add_tb;
  import spa_pkg::*;

  localparam logic [REQ_W-1:0] REQ_IGNORED = 2'd3;
  localparam int TERMS          = TERMS_PER_POLY_DEF;
  localparam int RANDOM_ITEMS   = 195;
  localparam int HOLD_CYCLES    = 300;
  localparam int TAIL_CYCLES    = 64;
  localparam int WATCHDOG_LIMIT = 4000;

  typedef struct {
    logic signed [COEF_W-1:0] coef;
    logic [EXPON_W-1:0]       expon;
  } poly_term_t;

  typedef struct {
    logic signed [COEF_W-1:0] coef;
    logic [EXPON_W-1:0]       expon;
    logic                     term_valid;
    logic                     last;
    logic                     overflow;
  } sum_term_t;

  class poly_sum_board;
    poly_term_t first_list[$];
    poly_term_t second_list[$];
    bit         load_ovf;
    sum_term_t  expected_terms[$];
    int errors, requests_seen, runs_seen, results_seen;
    int saturations, zero_drops, overflow_runs, empty_runs;

    function int pending();
      return expected_terms.size();
    endfunction

    function void push_term(logic signed [COEF_W-1:0] c, logic [EXPON_W-1:0] e, logic v);
      sum_term_t t;
      t.coef = c;
      t.expon = e;
      t.term_valid = v;
      t.last = 1'b0;
      t.overflow = load_ovf;
      expected_terms.push_back(t);
    endfunction

    // Note one accepted request; a run expands into its result terms.
    function void note_request(logic [REQ_W-1:0] kind, logic signed [COEF_W-1:0] c,
                               logic [EXPON_W-1:0] e);
      poly_term_t t;
      int i, j, n;
      longint s;
      t.coef = c;
      t.expon = e;
      if (kind == REQ_IGNORED) return;
      requests_seen++;
      if (kind == REQ_LOAD_A || kind == REQ_LOAD_B) begin
        if (kind == REQ_LOAD_A && first_list.size() < TERMS) first_list.push_back(t);
        else if (kind == REQ_LOAD_B && second_list.size() < TERMS) second_list.push_back(t);
        else load_ovf = 1'b1;
        return;
      end
      runs_seen++;
      if (load_ovf) overflow_runs++;
      n = expected_terms.size();
      i = 0;
      j = 0;
      while (i < first_list.size() && j < second_list.size()) begin
        if (first_list[i].expon == second_list[j].expon) begin
          s = longint'(first_list[i].coef) + longint'(second_list[j].coef);
          if (s > longint'(COEF_MAX)) begin
            s = longint'(COEF_MAX);
            saturations++;
          end else if (s < longint'(COEF_MIN)) begin
            s = longint'(COEF_MIN);
            saturations++;
          end
          if (s != 0) push_term(COEF_W'(s), first_list[i].expon, 1'b1);
          else zero_drops++;
          i++;
          j++;
        end else if (first_list[i].expon > second_list[j].expon) begin
          push_term(first_list[i].coef, first_list[i].expon, 1'b1);
          i++;
        end else begin
          push_term(second_list[j].coef, second_list[j].expon, 1'b1);
          j++;
        end
      end
      for (; i < first_list.size(); i++) push_term(first_list[i].coef, first_list[i].expon, 1'b1);
      for (; j < second_list.size(); j++)
        push_term(second_list[j].coef, second_list[j].expon, 1'b1);
      if (expected_terms.size() == n) begin
        push_term('0, '0, 1'b0);
        empty_runs++;
      end
      expected_terms[expected_terms.size()-1].last = 1'b1;
      first_list.delete();
      second_list.delete();
      load_ovf = 1'b0;
    endfunction

    function void check_result(logic signed [COEF_W-1:0] c, logic [EXPON_W-1:0] e,
                               logic v, logic l, logic o);
      sum_term_t x;
      results_seen++;
      if (expected_terms.size() == 0) begin
        $error("result with nothing expected: sum_coef %0d sum_expon %0d", c, e);
        errors++;
        return;
      end
      x = expected_terms.pop_front();
      if (c !== x.coef) begin
        $error("sum_coef: expected %0d, actual %0d", x.coef, c);
        errors++;
      end
      if (e !== x.expon) begin
        $error("sum_expon: expected %0d, actual %0d", x.expon, e);
        errors++;
      end
      if (v !== x.term_valid) begin
        $error("term_valid: expected %0b, actual %0b", x.term_valid, v);
        errors++;
      end
      if (l !== x.last) begin
        $error("last: expected %0b, actual %0b", x.last, l);
        errors++;
      end
      if (o !== x.overflow) begin
        $error("overflow: expected %0b, actual %0b", x.overflow, o);
        errors++;
      end
    endfunction
  endclass

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     req_valid = 1'b0;
  logic                     req_stall;
  logic [REQ_W-1:0]         req_type = REQ_LOAD_A;
  logic signed [COEF_W-1:0] coef = '0;
  logic [EXPON_W-1:0]       expon = '0;
  logic                     res_valid;
  logic                     res_stall = 1'b0;
  logic signed [COEF_W-1:0] sum_coef;
  logic [EXPON_W-1:0]       sum_expon;
  logic                     term_valid;
  logic                     last;
  logic                     overflow;

  poly_sum_board board = new();
  bit sender_burst = 1'b0;
  bit long_hold_req = 1'b0;
  int idle_cycles = 0;

  sparse_polynomial_add u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_type  (req_type),
    .coef      (coef),
    .expon     (expon),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .sum_coef  (sum_coef),
    .sum_expon (sum_expon),
    .term_valid(term_valid),
    .last      (last),
    .overflow  (overflow)
  );

  always #1 clk = ~clk;

  // Check every accepted result and guard against a hung block.
  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall)
      board.check_result(sum_coef, sum_expon, term_valid, last, overflow);
    if (rst || (res_valid && !res_stall) || (req_valid && !req_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $error("no handshake for %0d cycles", WATCHDOG_LIMIT);
      $display("Test completed with failures");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Result side: random stall before each result, calm stretches, one long hold on request.
  initial begin
    int n;
    int calm_left;
    bit calm;
    calm_left = 0;
    calm = 1'b0;
    while (rst) @(posedge clk);
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        n = HOLD_CYCLES;
      end else begin
        if (calm_left == 0) begin
          calm_left = $urandom_range(8, 24);
          calm = ($urandom_range(0, 2) == 0);
        end
        calm_left--;
        n = calm ? 0 : $urandom_range(0, 12);
      end
      if (n > 0) begin
        res_stall <= 1'b1;
        repeat (n) @(posedge clk);
        res_stall <= 1'b0;
      end
      do @(posedge clk); while (!(res_valid && !res_stall) && !long_hold_req);
    end
  end

  task automatic send_request(input logic [REQ_W-1:0] kind, input logic signed [COEF_W-1:0] c,
                              input logic [EXPON_W-1:0] e);
    int gap;
    gap = sender_burst ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req_type <= kind;
    coef <= c;
    expon <= e;
    do @(posedge clk); while (!(req_valid && !req_stall));
    board.note_request(kind, c, e);
  endtask

  // Hold the request side until every expected term has come back.
  task automatic drain_results();
    req_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  function automatic logic signed [COEF_W-1:0] random_coef();
    int unit;
    unit = int'($urandom_range(0, 8)) - 4;
    case ($urandom_range(0, 5))
      0: return COEF_MAX - COEF_W'($urandom_range(0, 3));
      1: return COEF_MIN + COEF_W'($urandom_range(0, 3));
      2: return COEF_W'(unit * 65536);
      3: return '0;
      default: return COEF_W'($urandom);
    endcase
  endfunction

  // Build two lists from one pool of exponents, descending unless scrambled, some shared,
  // then load them interleaved and (usually) run.
  task automatic load_poly_pair(input int pool_size, input bit scrambled, input bit overfill,
                                input bit with_run);
    int e_cur, k, pick;
    poly_term_t first_q[$];
    poly_term_t second_q[$];
    poly_term_t t;
    e_cur = ($urandom_range(0, 3) == 0) ? 65535 : $urandom_range(pool_size, 65535);
    for (k = 0; k < pool_size && e_cur >= 0; k++) begin
      pick = $urandom_range(0, 2);
      t.expon = scrambled ? EXPON_W'($urandom) : EXPON_W'(e_cur);
      t.coef = random_coef();
      if (pick != 1) first_q.push_back(t);
      if (pick != 0) begin
        if (pick == 2) begin
          case ($urandom_range(0, 3))
            0: t.coef = -t.coef;
            1: ;
            default: t.coef = random_coef();
          endcase
        end
        second_q.push_back(t);
      end
      e_cur -= $urandom_range(1, e_cur / (pool_size - k) + 1);
    end
    if (overfill) begin
      if (e_cur < 0) e_cur = 0;
      if ($urandom_range(0, 1) == 0) begin
        while (first_q.size() < TERMS + 2) begin
          t.coef = random_coef();
          t.expon = EXPON_W'(e_cur);
          first_q.push_back(t);
          if (e_cur > 0) e_cur--;
        end
      end else begin
        while (second_q.size() < TERMS + 1 + $urandom_range(0, 1)) begin
          t.coef = random_coef();
          t.expon = EXPON_W'(e_cur);
          second_q.push_back(t);
          if (e_cur > 0) e_cur--;
        end
      end
    end
    while (first_q.size() != 0 || second_q.size() != 0) begin
      if ($urandom_range(0, 15) == 0)
        send_request(REQ_IGNORED, COEF_W'($urandom), EXPON_W'($urandom));
      if (second_q.size() == 0 || (first_q.size() != 0 && $urandom_range(0, 1) == 0)) begin
        t = first_q.pop_front();
        send_request(REQ_LOAD_A, t.coef, t.expon);
      end else begin
        t = second_q.pop_front();
        send_request(REQ_LOAD_B, t.coef, t.expon);
      end
    end
    if (with_run) send_request(REQ_RUN, COEF_W'($urandom), EXPON_W'($urandom));
  endtask

  initial begin
    int seq_idx;
    int start_count;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty run, saturation both ways, cancelling pair, zero unpaired term,
    // exponent extremes, ignored request type.
    send_request(REQ_RUN, '0, '0);
    send_request(REQ_LOAD_A, COEF_MAX, 16'hFFFF);
    send_request(REQ_LOAD_A, 32'sh0005_0000, 16'd100);
    send_request(REQ_LOAD_A, '0, 16'd3);
    send_request(REQ_LOAD_B, 32'sd1, 16'hFFFF);
    send_request(REQ_LOAD_B, -32'sh0005_0000, 16'd100);
    send_request(REQ_LOAD_B, COEF_MIN, 16'd0);
    send_request(REQ_RUN, 32'sh1234_5678, 16'hABCD);
    send_request(REQ_LOAD_A, COEF_MIN, 16'd7);
    send_request(REQ_LOAD_B, -32'sd1, 16'd7);
    send_request(REQ_IGNORED, COEF_MAX, 16'hFFFF);
    send_request(REQ_RUN, '0, '0);
    send_request(REQ_LOAD_A, 32'sh0003_0000, 16'd5);
    send_request(REQ_LOAD_B, -32'sh0003_0000, 16'd5);
    send_request(REQ_RUN, '0, '0);
    drain_results();

    start_count = board.requests_seen;
    seq_idx = 0;
    while (board.requests_seen - start_count < RANDOM_ITEMS) begin
      if (seq_idx == 4) begin
        // Hold the result side for a long stretch while loads keep coming back to back.
        drain_results();
        long_hold_req = 1'b1;
        sender_burst = 1'b1;
        load_poly_pair(8, 1'b0, 1'b0, 1'b1);
        load_poly_pair(10, 1'b0, 1'b0, 1'b1);
      end else begin
        sender_burst = ($urandom_range(0, 3) == 0);
        load_poly_pair($urandom_range(0, 10), $urandom_range(0, 9) == 0,
                       $urandom_range(0, 7) == 0, $urandom_range(0, 9) != 0);
      end
      seq_idx++;
      if (seq_idx % 8 == 0) drain_results();
    end
    sender_burst = 1'b0;
    send_request(REQ_RUN, '0, '0);
    drain_results();

    if (board.pending() != 0) begin
      $error("%0d expected result terms never arrived", board.pending());
      board.errors++;
    end
    $display("Run covered %0d requests and %0d runs producing %0d result terms.",
             board.requests_seen, board.runs_seen, board.results_seen);
    $display("Saturated sums %0d, cancelled pairs %0d, runs with dropped loads %0d, empty %0d.",
             board.saturations, board.zero_drops, board.overflow_runs, board.empty_runs);
    if (board.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
